>>> src/hevc_parameter_set_hasher_unit_macros.svh
// Assertion helpers for the hasher back end.
`ifndef HEVC_PARAMETER_SET_HASHER_UNIT_MACROS_SVH
`define HEVC_PARAMETER_SET_HASHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HPSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define HPSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define HPSH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPSH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/hpsh_pkg.sv
package hpsh_pkg;

  localparam int unsigned POS_W   = 29;
  localparam int unsigned COUNT_W = 26;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned HASH_W  = 64;

  localparam int unsigned MAX_MESSAGE_BYTES = 268435456;
  localparam int unsigned FALLBACK_BYTES    = 1024;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

  localparam logic [5:0] NAL_TYPE_VPS = 6'd32;
  localparam logic [5:0] NAL_TYPE_PPS = 6'd34;

  // One classified byte handed from the parser to the hashing side.
  typedef struct packed {
    logic [7:0] data;
    logic       prefix_en;
    logic       set_en;
    logic       set_inc;
    logic       last;
  } qent_t;

  // FNV-1a 64 step; the prime is 2^40 + 0x1B3, so the product is a sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

>>> src/hpsh_front.sv
module hpsh_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic [28:0]           total_length_i,
  input  logic                  last_byte_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output hpsh_pkg::qent_t       q_entry_o
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_UNIT,
    PH_STOP
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [hpsh_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [hpsh_pkg::LEN_W-1:0]   acc_q, acc_d;
  logic [1:0]                   lcnt_q, lcnt_d;
  logic [hpsh_pkg::LEN_W-1:0]   left_q, left_d;
  logic                         hashed_q, hashed_d;

  logic [28:0]                  total_c;
  logic [29:0]                  remain;
  logic [hpsh_pkg::LEN_W-1:0]   acc_shift;
  logic [hpsh_pkg::LEN_W-1:0]   left_dec;
  logic [5:0]                   unit_type;
  logic                         is_set;
  logic                         prefix_en;
  logic                         set_en;
  logic                         set_inc;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign total_c = (total_length_i > 29'(hpsh_pkg::MAX_MESSAGE_BYTES)) ?
                   29'(hpsh_pkg::MAX_MESSAGE_BYTES) : total_length_i;
  assign prefix_en = (pos_q < total_c) && (pos_q < 29'(hpsh_pkg::FALLBACK_BYTES));
  assign remain    = {1'b0, total_c} - ({1'b0, pos_q} + 30'd1);
  assign acc_shift = {acc_q[23:0], data_byte_i};
  assign left_dec  = left_q - 32'd1;
  assign unit_type = data_byte_i[6:1];
  assign is_set    = (left_q == acc_q) && (acc_q >= 32'd2) &&
                     (unit_type >= hpsh_pkg::NAL_TYPE_VPS) &&
                     (unit_type <= hpsh_pkg::NAL_TYPE_PPS);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    lcnt_d   = lcnt_q;
    left_d   = left_q;
    hashed_d = hashed_q;
    set_en   = 1'b0;
    set_inc  = 1'b0;
    pos_d    = (pos_q == '1) ? pos_q : pos_q + 29'd1;
    unique case (phase_q)
      PH_LEN: begin
        if ((lcnt_q == 2'd0) && (({1'b0, pos_q} + 30'd4) > {1'b0, total_c})) begin
          phase_d = PH_STOP;
        end else begin
          acc_d  = acc_shift;
          lcnt_d = lcnt_q + 2'd1;
          if (lcnt_q == 2'd3) begin
            if ((acc_shift == '0) || (acc_shift > {2'b00, remain})) begin
              phase_d = PH_STOP;
            end else begin
              left_d   = acc_shift;
              hashed_d = 1'b0;
              phase_d  = PH_UNIT;
            end
          end
        end
      end
      PH_UNIT: begin
        set_inc = is_set;
        set_en  = is_set || hashed_q;
        if (left_dec == '0) begin
          left_d   = left_dec;
          phase_d  = PH_LEN;
          hashed_d = 1'b0;
          acc_d    = '0;
          lcnt_d   = 2'd0;
        end else begin
          left_d   = left_dec;
          hashed_d = is_set || hashed_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_entry_o.data      = data_byte_i;
  assign q_entry_o.prefix_en = prefix_en;
  assign q_entry_o.set_en    = set_en;
  assign q_entry_o.set_inc   = set_inc;
  assign q_entry_o.last      = last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      pos_q    <= '0;
      acc_q    <= '0;
      lcnt_q   <= 2'd0;
      left_q   <= '0;
      hashed_q <= 1'b0;
    end else if (q_push_o) begin
      if (last_byte_i) begin
        phase_q  <= PH_LEN;
        pos_q    <= '0;
        acc_q    <= '0;
        lcnt_q   <= 2'd0;
        left_q   <= '0;
        hashed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        acc_q    <= acc_d;
        lcnt_q   <= lcnt_d;
        left_q   <= left_d;
        hashed_q <= hashed_d;
      end
    end
  end

endmodule

>>> src/hpsh_fifo.sv
module hpsh_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hpsh_pkg::qent_t wr_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hpsh_pkg::qent_t rd_entry_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  hpsh_pkg::qent_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign valid_o    = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/hpsh_back.sv
`include "hevc_parameter_set_hasher_unit_macros.svh"

module hpsh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  hpsh_pkg::qent_t               q_entry_i,
  output logic                          pop_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [hpsh_pkg::HASH_W-1:0]   m_key_o,
  output logic [hpsh_pkg::COUNT_W-1:0]  m_set_count_o,
  output logic                          m_used_fallback_o
);

  logic [hpsh_pkg::HASH_W-1:0]  prefix_hash_q, prefix_hash_d;
  logic [hpsh_pkg::HASH_W-1:0]  set_hash_q, set_hash_d;
  logic [hpsh_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic                         out_valid_q;
  logic [hpsh_pkg::HASH_W-1:0]  key_q;
  logic [hpsh_pkg::COUNT_W-1:0] set_count_q;
  logic                         fallback_q;
  logic                         out_free;
  logic                         found;

  assign out_free = !out_valid_q || m_tready_i;
  assign pop_o    = q_valid_i && (!q_entry_i.last || out_free);

  assign prefix_hash_d = q_entry_i.prefix_en ?
                         hpsh_pkg::fnv_step(prefix_hash_q, q_entry_i.data) : prefix_hash_q;
  assign set_hash_d    = q_entry_i.set_en ?
                         hpsh_pkg::fnv_step(set_hash_q, q_entry_i.data) : set_hash_q;
  assign cnt_d         = (q_entry_i.set_inc && (cnt_q != '1)) ? cnt_q + 26'd1 : cnt_q;
  assign found         = (cnt_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_hash_q <= hpsh_pkg::FNV_BASIS;
      set_hash_q    <= hpsh_pkg::FNV_BASIS;
      cnt_q         <= '0;
    end else if (pop_o) begin
      if (q_entry_i.last) begin
        prefix_hash_q <= hpsh_pkg::FNV_BASIS;
        set_hash_q    <= hpsh_pkg::FNV_BASIS;
        cnt_q         <= '0;
      end else begin
        prefix_hash_q <= prefix_hash_d;
        set_hash_q    <= set_hash_d;
        cnt_q         <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && q_entry_i.last) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_entry_i.last) begin
      key_q       <= (found ? set_hash_d : prefix_hash_d) ^ {38'd0, cnt_d};
      set_count_q <= cnt_d;
      fallback_q  <= !found;
    end
  end

  assign m_tvalid_o        = out_valid_q;
  assign m_key_o           = key_q;
  assign m_set_count_o     = set_count_q;
  assign m_used_fallback_o = fallback_q;

  `HPSH_ASSERT_IMP(a_fallback_flag, clk_i, rst_ni, m_tvalid_o, m_used_fallback_o == (m_set_count_o == '0))
  `HPSH_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, pop_o && q_entry_i.last, (cnt_q == '0) && (prefix_hash_q == hpsh_pkg::FNV_BASIS))
  `HPSH_ASSERT_IMP(a_last_needs_room, clk_i, rst_ni, pop_o && q_entry_i.last, !m_tvalid_o || m_tready_i)

endmodule

>>> src/hevc_parameter_set_hasher_unit.sv
// Takes one byte per cycle unless the queue is full; a byte that is not the last yields no result.
// The last byte of a message is written into the queue; once it is popped with the output free,
// the result word is registered and turns valid.
// Throughput is one byte per cycle without stalls, set by the combinational FNV-1a step in the back end.
// A four-word queue separates the parser from the hashing side so each stalls on its own.
// Reset (rst_ni low, asynchronous) empties the queue and returns parse state, hashes and count to start.
module hevc_parameter_set_hasher_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // data_byte [7:0], total_length [36:8], zero fill
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // key [63:0], set_count [89:64], zero fill
  output logic         m_axis_tuser   // used_fallback
);

  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  hpsh_pkg::qent_t wr_entry;
  hpsh_pkg::qent_t rd_entry;
  logic [63:0]     key;
  logic [25:0]     set_count;

  hpsh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata[7:0]),
    .total_length_i (s_axis_tdata[36:8]),
    .last_byte_i    (s_axis_tlast),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (wr_entry)
  );

  hpsh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .rd_entry_o (rd_entry)
  );

  hpsh_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_entry_i         (rd_entry),
    .pop_o             (q_pop),
    .m_tvalid_o        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .m_key_o           (key),
    .m_set_count_o     (set_count),
    .m_used_fallback_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, set_count, key};

endmodule
